FILE: hdl/assert_macros.svh
// Assertion macros for the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked out of reset only.
`define CHK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("check failed");

// Checked at every edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("check failed");

`endif

FILE: hdl/dpb_pkg.sv
`timescale 1ns / 1ps

package dpb_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COORD_BITS_MAX = 14;

    localparam int CFG_DIM_W  = 13;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;

    // Offset magnitude |16*pos - center|, wide enough for COORD_BITS_MAX.
    localparam int OFFS_W = COORD_BITS_MAX + 4;
    // Dividend: |offs| * depth * 16.
    localparam int NUM_W  = OFFS_W + 16 + 4;
    localparam int STEP_W = $clog2(NUM_W);
    localparam int REM_W  = 17;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_CENTER_X     = 3'd2,
        CFG_CENTER_Y     = 3'd3,
        CFG_FOCAL_X      = 3'd4,
        CFG_FOCAL_Y      = 3'd5,
        CFG_NEAR_CLIP    = 3'd6,
        CFG_FAR_CLIP     = 3'd7
    } t_cfg_addr;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] image_width;
        logic [CFG_DIM_W-1:0] image_height;
        logic [15:0]          center_x;
        logic [15:0]          center_y;
        logic [15:0]          near_clip_mm;
        logic [15:0]          far_clip_mm;
    } t_cfg;

    typedef struct packed {
        logic [15:0] depth_mm;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } t_pixel;

    typedef struct packed {
        logic               point_kept;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [15:0]        point_z;
        logic [7:0]         point_red;
        logic [7:0]         point_green;
        logic [7:0]         point_blue;
        logic               frame_end;
    } t_point;

    typedef struct packed {
        logic              kept;
        logic              frame_end;
        logic              x_neg;
        logic [OFFS_W-1:0] x_mag;
        logic              y_neg;
        logic [OFFS_W-1:0] y_mag;
        logic [15:0]       depth_mm;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } t_back_state;

endpackage

FILE: hdl/depth_pixel_backprojection.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in_data   (t_pixel)
// out       output     o_out_valid / i_out_stall o_out_data  (t_point)
// cfg       input      i_cfg_we                  i_cfg_addr, i_cfg_wdata
//
// Kept pixel in the back end: pop, multiply, 38 divide steps, output load;
// the bit-serial divider sets the rate. Dropped pixel: pop, output load.
// Front accepts while the 2-entry queue has room, independent of the back end.
// Synchronous active-low reset clears counters, queue, FSM and config to defaults.
// Output register holds its transaction while i_out_stall is high.

module depth_pixel_backprojection
    import dpb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_pixel                i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_point                o_out_data
);

    t_cfg        r_cfg;
    logic [15:0] r_focal_x;
    logic [15:0] r_focal_y;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_job push_job;
    t_job head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= CFG_DIM_W'(640);
            r_cfg.image_height <= CFG_DIM_W'(480);
            r_cfg.center_x     <= 16'd0;
            r_cfg.center_y     <= 16'd0;
            r_cfg.near_clip_mm <= 16'd100;
            r_cfg.far_clip_mm  <= 16'd2000;
            r_focal_x          <= 16'd16;
            r_focal_y          <= 16'd16;
        end else if (i_cfg_we) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_wdata[CFG_DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_wdata[CFG_DIM_W-1:0];
                CFG_CENTER_X:     r_cfg.center_x     <= i_cfg_wdata;
                CFG_CENTER_Y:     r_cfg.center_y     <= i_cfg_wdata;
                CFG_FOCAL_X:      r_focal_x          <= i_cfg_wdata;
                CFG_FOCAL_Y:      r_focal_y          <= i_cfg_wdata;
                CFG_NEAR_CLIP:    r_cfg.near_clip_mm <= i_cfg_wdata;
                CFG_FAR_CLIP:     r_cfg.far_clip_mm  <= i_cfg_wdata;
                default:          r_focal_x          <= r_focal_x;
            endcase
        end
    end

    dpb_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in_valid),
        .i_pixel  (i_in_data),
        .i_q_full (q_full),
        .o_stall  (o_in_stall),
        .o_push   (q_push),
        .o_job    (push_job)
    );

    dpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    dpb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_focal_x (r_focal_x),
        .i_focal_y (r_focal_y),
        .i_q_empty (q_empty),
        .i_job     (head_job),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_point   (o_out_data)
    );

endmodule

FILE: hdl/dpb_queue.sv
`timescale 1ns / 1ps

module dpb_queue
    import dpb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: hdl/dpb_front.sv
`timescale 1ns / 1ps

module dpb_front
    import dpb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    input  t_pixel i_pixel,
    input  logic   i_q_full,
    output logic   o_stall,
    output logic   o_push,
    output t_job   o_job
);

    localparam int LW = (COORD_BITS + 1 > CFG_DIM_W) ? COORD_BITS + 1 : CFG_DIM_W;

    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;

    logic [LW-1:0]     dim_max;
    logic [LW-1:0]     w_ext;
    logic [LW-1:0]     h_ext;
    logic [LW-1:0]     w_eff;
    logic [LW-1:0]     h_eff;
    logic [LW-1:0]     col_inc;
    logic [LW-1:0]     row_inc;
    logic              row_last;
    logic              frame_last;
    logic              kept;
    logic [OFFS_W:0]   diff_x;
    logic [OFFS_W:0]   diff_y;
    logic [OFFS_W:0]   abs_x;
    logic [OFFS_W:0]   abs_y;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        dim_max = LW'(1) << COORD_BITS;
        w_ext   = LW'(i_cfg.image_width);
        h_ext   = LW'(i_cfg.image_height);
        w_eff   = w_ext;
        h_eff   = h_ext;
        if (w_ext == '0) begin
            w_eff = LW'(1);
        end else if (w_ext > dim_max) begin
            w_eff = dim_max;
        end
        if (h_ext == '0) begin
            h_eff = LW'(1);
        end else if (h_ext > dim_max) begin
            h_eff = dim_max;
        end
        col_inc    = LW'(r_col) + LW'(1);
        row_inc    = LW'(r_row) + LW'(1);
        row_last   = (col_inc >= w_eff);
        frame_last = row_last && (row_inc >= h_eff);
        kept       = (i_pixel.depth_mm > i_cfg.near_clip_mm) &&
                     (i_pixel.depth_mm <= i_cfg.far_clip_mm);
    end

    // Signed offset 16*pos - center, split into sign and magnitude.
    always_comb begin
        diff_x = ((OFFS_W + 1)'(r_col) << 4) - (OFFS_W + 1)'(i_cfg.center_x);
        diff_y = ((OFFS_W + 1)'(r_row) << 4) - (OFFS_W + 1)'(i_cfg.center_y);
        abs_x  = diff_x[OFFS_W] ? -diff_x : diff_x;
        abs_y  = diff_y[OFFS_W] ? -diff_y : diff_y;

        o_job.kept      = kept;
        o_job.frame_end = frame_last;
        o_job.x_neg     = diff_x[OFFS_W];
        o_job.x_mag     = abs_x[OFFS_W-1:0];
        o_job.y_neg     = diff_y[OFFS_W];
        o_job.y_mag     = abs_y[OFFS_W-1:0];
        o_job.depth_mm  = i_pixel.depth_mm;
        o_job.red       = i_pixel.red;
        o_job.green     = i_pixel.green;
        o_job.blue      = i_pixel.blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            if (row_last) begin
                r_col <= '0;
                r_row <= frame_last ? '0 : row_inc[COORD_BITS-1:0];
            end else begin
                r_col <= col_inc[COORD_BITS-1:0];
            end
        end
    end

endmodule

FILE: hdl/dpb_back.sv
`timescale 1ns / 1ps

module dpb_back
    import dpb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_focal_x,
    input  logic [15:0] i_focal_y,
    input  logic        i_q_empty,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output t_point      o_point
);

    t_back_state       r_state;
    t_back_state       n_state;
    t_job              r_job;
    logic [NUM_W-1:0]  r_num_x;
    logic [NUM_W-1:0]  r_num_y;
    logic [REM_W-1:0]  r_rem_x;
    logic [REM_W-1:0]  r_rem_y;
    logic [STEP_W-1:0] r_step;
    t_point            r_out;
    logic              r_out_valid;

    logic                 out_load;
    logic                 div_last;
    logic [15:0]          den_x;
    logic [15:0]          den_y;
    logic [OFFS_W+15:0]   prod_x;
    logic [OFFS_W+15:0]   prod_y;
    logic [REM_W-1:0]     sh_x;
    logic [REM_W-1:0]     sh_y;
    logic                 ge_x;
    logic                 ge_y;
    t_point               pt;

    // Truncated quotient magnitude to saturated signed 32 bits.
    function automatic logic [31:0] sat32(input logic neg, input logic [NUM_W-1:0] q);
        logic over;
        logic [31:0] res;
        if (neg) begin
            over = (|q[NUM_W-1:32]) || (q[31] && (|q[30:0]));
            res  = over ? 32'h8000_0000 : -q[31:0];
        end else begin
            over = |q[NUM_W-1:31];
            res  = over ? 32'h7FFF_FFFF : q[31:0];
        end
        return res;
    endfunction

    assign den_x    = (i_focal_x == '0) ? 16'd1 : i_focal_x;
    assign den_y    = (i_focal_y == '0) ? 16'd1 : i_focal_y;
    assign prod_x   = (OFFS_W + 16)'(r_job.x_mag) * (OFFS_W + 16)'(r_job.depth_mm);
    assign prod_y   = (OFFS_W + 16)'(r_job.y_mag) * (OFFS_W + 16)'(r_job.depth_mm);
    assign div_last = (r_step == STEP_W'(NUM_W - 1));

    // One restoring step per cycle on each axis.
    always_comb begin
        sh_x = {r_rem_x[REM_W-2:0], r_num_x[NUM_W-1]};
        sh_y = {r_rem_y[REM_W-2:0], r_num_y[NUM_W-1]};
        ge_x = (sh_x >= REM_W'(den_x));
        ge_y = (sh_y >= REM_W'(den_y));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_job.kept ? S_MUL : S_DONE;
                end
            end
            S_MUL: n_state = S_DIV;
            S_DIV: begin
                if (div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE:  o_pop    = !i_q_empty;
            S_MUL:   o_pop    = 1'b0;
            S_DIV:   o_pop    = 1'b0;
            S_DONE:  out_load = !r_out_valid || !i_stall;
            default: o_pop    = 1'b0;
        endcase
    end

    always_comb begin
        pt           = '0;
        pt.frame_end = r_job.frame_end;
        if (r_job.kept) begin
            pt.point_kept  = 1'b1;
            pt.point_x     = sat32(r_job.x_neg, r_num_x);
            pt.point_y     = sat32(r_job.y_neg, r_num_y);
            pt.point_z     = r_job.depth_mm;
            pt.point_red   = r_job.red;
            pt.point_green = r_job.green;
            pt.point_blue  = r_job.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == S_MUL) begin
            r_num_x <= {prod_x, 4'b0000};
            r_num_y <= {prod_y, 4'b0000};
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_step  <= '0;
        end else if (r_state == S_DIV) begin
            r_rem_x <= ge_x ? sh_x - REM_W'(den_x) : sh_x;
            r_rem_y <= ge_y ? sh_y - REM_W'(den_y) : sh_y;
            r_num_x <= {r_num_x[NUM_W-2:0], ge_x};
            r_num_y <= {r_num_y[NUM_W-2:0], ge_y};
            r_step  <= r_step + STEP_W'(1);
        end
        if (out_load) begin
            r_out <= pt;
        end
    end

    assign o_valid = r_out_valid;
    assign o_point = r_out;

endmodule

FILE: hdl/dpb_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dpb_checker
    import dpb_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input t_pixel                i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_point                o_out_data
);

    // Stalled result transaction holds.
    `CHK_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))

    // A dropped point carries only the frame-end flag.
    `CHK_ASSERT(a_drop_zero, (o_out_valid && !o_out_data.point_kept) |-> ((o_out_data.point_x == 0) && (o_out_data.point_y == 0) && (o_out_data.point_z == 0) && (o_out_data.point_red == 0) && (o_out_data.point_green == 0) && (o_out_data.point_blue == 0)))

    // A kept point lies beyond the near clip, so its depth is nonzero.
    `CHK_ASSERT(a_kept_depth, (o_out_valid && o_out_data.point_kept) |-> (o_out_data.point_z != 16'd0))

    // Reset empties the output register.
    `CHK_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid)

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (.*);

FILE: tb/dpb_point_checker.sv
`timescale 1ns / 1ps

module dpb_point_checker
    import dpb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_pixel                i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_point                i_out_data,
    output int                    o_mismatches,
    output int                    o_pending
);

    localparam int     DIM_LIMIT = 1 << COORD_BITS_DEF;
    localparam longint SAT_HI    = 64'sd2147483647;
    localparam longint SAT_LO    = -SAT_HI - 1;

    logic [CFG_DIM_W-1:0]      width_reg;
    logic [CFG_DIM_W-1:0]      height_reg;
    logic [15:0]               cx_reg;
    logic [15:0]               cy_reg;
    logic [15:0]               fx_reg;
    logic [15:0]               fy_reg;
    logic [15:0]               near_reg;
    logic [15:0]               far_reg;
    logic [COORD_BITS_DEF-1:0] col_pos;
    logic [COORD_BITS_DEF-1:0] row_pos;
    t_point                    expected_points[$];
    int                        mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic int clamp_dim(logic [CFG_DIM_W-1:0] d);
        if (d == '0) return 1;
        if (int'(d) > DIM_LIMIT) return DIM_LIMIT;
        return int'(d);
    endfunction

    // (16*pos - center) * z * 16 / focal, truncated toward zero, saturated to 32 bits
    function automatic logic [31:0] backproject_axis(logic [COORD_BITS_DEF-1:0] pos,
                                                     logic [15:0] center,
                                                     logic [15:0] focal,
                                                     logic [15:0] z);
        longint offs;
        longint num;
        longint den;
        longint q;
        offs = 16 * longint'(pos) - longint'(center);
        num  = offs * longint'(z) * 16;
        den  = (focal == '0) ? 64'sd1 : longint'(focal);
        q    = num / den;
        if (q > SAT_HI) q = SAT_HI;
        else if (q < SAT_LO) q = SAT_LO;
        return q[31:0];
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch_blk
        t_point want;
        t_point got;
        bit     row_last;
        bit     frame_last;
        if (!i_rst_n) begin
            width_reg  = 13'd640;
            height_reg = 13'd480;
            cx_reg     = '0;
            cy_reg     = '0;
            fx_reg     = 16'd16;
            fy_reg     = 16'd16;
            near_reg   = 16'd100;
            far_reg    = 16'd2000;
            col_pos    = '0;
            row_pos    = '0;
            expected_points.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_addr'(i_cfg_addr))
                    CFG_IMAGE_WIDTH:  width_reg  = i_cfg_wdata[CFG_DIM_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg = i_cfg_wdata[CFG_DIM_W-1:0];
                    CFG_CENTER_X:     cx_reg     = i_cfg_wdata;
                    CFG_CENTER_Y:     cy_reg     = i_cfg_wdata;
                    CFG_FOCAL_X:      fx_reg     = i_cfg_wdata;
                    CFG_FOCAL_Y:      fy_reg     = i_cfg_wdata;
                    CFG_NEAR_CLIP:    near_reg   = i_cfg_wdata;
                    CFG_FAR_CLIP:     far_reg    = i_cfg_wdata;
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                row_last   = (int'(col_pos) + 1) >= clamp_dim(width_reg);
                frame_last = row_last && ((int'(row_pos) + 1) >= clamp_dim(height_reg));
                want = '0;
                if (i_in_data.depth_mm > near_reg && i_in_data.depth_mm <= far_reg) begin
                    want.point_kept  = 1'b1;
                    want.point_x     = backproject_axis(col_pos, cx_reg, fx_reg,
                                                        i_in_data.depth_mm);
                    want.point_y     = backproject_axis(row_pos, cy_reg, fy_reg,
                                                        i_in_data.depth_mm);
                    want.point_z     = i_in_data.depth_mm;
                    want.point_red   = i_in_data.red;
                    want.point_green = i_in_data.green;
                    want.point_blue  = i_in_data.blue;
                end
                want.frame_end = frame_last;
                expected_points = {expected_points, want};
                if (row_last) begin
                    col_pos = '0;
                    row_pos = frame_last ? '0 : row_pos + 1'b1;
                end else begin
                    col_pos = col_pos + 1'b1;
                end
            end

            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (expected_points.size() == 0) begin
                    $display("%0t: point with no transaction waiting: %h", $time, got);
                    mismatch_count++;
                end else begin
                    want = expected_points.pop_front();
                    compare_field("point_kept", want.point_kept, got.point_kept);
                    compare_field("point_x", want.point_x, got.point_x);
                    compare_field("point_y", want.point_y, got.point_y);
                    compare_field("point_z", want.point_z, got.point_z);
                    compare_field("point_red", want.point_red, got.point_red);
                    compare_field("point_green", want.point_green, got.point_green);
                    compare_field("point_blue", want.point_blue, got.point_blue);
                    compare_field("frame_end", want.frame_end, got.frame_end);
                end
            end
        end
        o_pending = expected_points.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dpb_pkg::*;

    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 500;
    localparam int DEEP_ITEMS     = 200;

    typedef enum int {
        TRAFFIC_FREE,
        TRAFFIC_SLOW_SRC,
        TRAFFIC_SLOW_SINK,
        TRAFFIC_BOTH
    } t_traffic;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_pixel                i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_point                o_out_data;

    int          mismatches;
    int          pending;
    int          idle_pct     = 0;
    int          stall_pct    = 0;
    bit          hold_req     = 1'b0;
    int          stuck_cycles = 0;
    logic [15:0] cur_near     = 16'd100;
    logic [15:0] cur_far      = 16'd2000;

    depth_pixel_backprojection u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    dpb_point_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver side; a hold-off request keeps stall high for a long stretch
    always begin
        @(negedge i_clk);
        if (hold_req) begin
            i_out_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge i_clk);
            hold_req = 1'b0;
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic t_pixel make_pixel(logic [15:0] depth, logic [7:0] red,
                                          logic [7:0] green, logic [7:0] blue);
        t_pixel px;
        px.depth_mm = depth;
        px.red      = red;
        px.green    = green;
        px.blue     = blue;
        return px;
    endfunction

    function automatic t_pixel random_pixel();
        logic [15:0] d;
        case ($urandom_range(9))
            0: d = cur_near;
            1: d = cur_near + 16'd1;
            2: d = cur_far;
            3: d = cur_far + 16'd1;
            4, 5: d = 16'($urandom);
            default: d = (cur_far > cur_near) ?
                         16'($urandom_range(cur_far, cur_near + 1)) : 16'($urandom);
        endcase
        return make_pixel(d, 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // entered and left at a falling edge; valid stays high for a back-to-back transaction
    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_addr idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
    endtask

    task automatic load_config(input logic [15:0] w, input logic [15:0] h,
                               input logic [15:0] cx, input logic [15:0] cy,
                               input logic [15:0] fx, input logic [15:0] fy,
                               input logic [15:0] nr, input logic [15:0] fr);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_FOCAL_X, fx);
        write_reg(CFG_FOCAL_Y, fy);
        write_reg(CFG_NEAR_CLIP, nr);
        write_reg(CFG_FAR_CLIP, fr);
        i_cfg_we <= 1'b0;
        cur_near = nr;
        cur_far  = fr;
        @(negedge i_clk);
    endtask

    task automatic random_config(input bit deep);
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] nr;
        logic [15:0] fr;
        case ($urandom_range(5))
            0: w = 16'd1;
            1, 2: w = 16'($urandom_range(2, 8));
            3: w = 16'($urandom_range(9, 64));
            4: w = 16'($urandom);
            default: w = 16'd0;
        endcase
        case ($urandom_range(3))
            0: h = 16'd1;
            1: h = 16'($urandom_range(2, 6));
            2: h = 16'($urandom);
            default: h = 16'd0;
        endcase
        case ($urandom_range(3))
            0: cx = 16'd0;
            1: cx = 16'hFFFF;
            default: cx = 16'($urandom);
        endcase
        case ($urandom_range(3))
            0: cy = 16'd0;
            1: cy = 16'hFFFF;
            default: cy = 16'($urandom);
        endcase
        case ($urandom_range(4))
            0: fx = 16'd0;
            1: fx = 16'($urandom_range(1, 15));
            2: fx = 16'hFFFF;
            default: fx = 16'($urandom_range(16, 2000));
        endcase
        case ($urandom_range(4))
            0: fy = 16'd0;
            1: fy = 16'($urandom_range(1, 15));
            2: fy = 16'hFFFF;
            default: fy = 16'($urandom_range(16, 2000));
        endcase
        case ($urandom_range(4))
            0: begin
                nr = 16'($urandom);
                fr = 16'($urandom);
            end
            1: begin
                nr = 16'd0;
                fr = 16'hFFFF;
            end
            2: begin
                nr = 16'($urandom);
                fr = nr;
            end
            default: begin
                nr = 16'($urandom_range(0, 20000));
                fr = nr + 16'($urandom_range(1, 40000));
            end
        endcase
        // wide rows with unit focal length push x into positive saturation
        if (deep) begin
            w  = 16'h1FFF;
            h  = 16'hFFFF;
            cx = 16'd0;
            cy = 16'd0;
            fx = 16'($urandom_range(0, 1));
            nr = 16'd0;
            fr = 16'hFFFF;
        end
        load_config(w, h, cx, cy, fx, fy, nr, fr);
    endtask

    task automatic set_traffic(input t_traffic mode);
        case (mode)
            TRAFFIC_FREE: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            TRAFFIC_SLOW_SRC: begin
                idle_pct  = 48;
                stall_pct = 0;
            end
            TRAFFIC_SLOW_SINK: begin
                idle_pct  = 0;
                stall_pct = 48;
            end
            default: begin
                idle_pct  = 21;
                stall_pct = 21;
            end
        endcase
    endtask

    initial begin : stimulus_blk
        int       sent;
        int       phase;
        int       count;
        t_traffic mode;
        sent  = 0;
        phase = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset geometry: clip boundaries and colour extremes
        send_pixel(make_pixel(16'd0, 8'h00, 8'h00, 8'h00));
        send_pixel(make_pixel(16'd100, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(16'd101, 8'hFF, 8'h00, 8'hFF));
        send_pixel(make_pixel(16'd2000, 8'h00, 8'hFF, 8'h00));
        send_pixel(make_pixel(16'd2001, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(16'd1500, 8'h55, 8'hAA, 8'h5A));
        wait_drained();

        // column already past the new width; zero focal; negative saturation
        load_config(16'd3, 16'd2, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'd0, 16'hFFFF);
        send_pixel(make_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(16'd1, 8'hA5, 8'h5A, 8'hC3));
        send_pixel(make_pixel(16'd0, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(16'hFFFF, 8'h00, 8'h00, 8'h00));
        send_pixel(make_pixel(16'h8000, 8'h3C, 8'hC3, 8'h0F));
        wait_drained();

        // zero geometry behaves as 1x1; near equal to far drops everything
        load_config(16'd0, 16'd0, 16'd16, 16'h8000, 16'hFFFF, 16'd16, 16'd500, 16'd500);
        send_pixel(make_pixel(16'd500, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(16'd501, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
        wait_drained();

        // oversized and high-bit geometry values
        load_config(16'hFFFF, 16'h2003, 16'h7FF8, 16'h0008, 16'h00FF, 16'hFFFF,
                    16'hFFFE, 16'hFFFF);
        send_pixel(make_pixel(16'hFFFF, 8'h81, 8'h42, 8'h24));
        send_pixel(make_pixel(16'hFFFE, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(16'h8000, 8'hFF, 8'hFF, 8'hFF));
        wait_drained();

        // near above far
        load_config(16'd5, 16'd5, 16'd40, 16'd40, 16'd32, 16'd32, 16'd3000, 16'd1000);
        send_pixel(make_pixel(16'd2000, 8'h12, 8'h34, 8'h56));
        send_pixel(make_pixel(16'hFFFF, 8'h78, 8'h9A, 8'hBC));
        wait_drained();

        while (sent < RANDOM_ITEMS) begin
            mode = t_traffic'(phase % 4);
            random_config(phase == 1);
            set_traffic(mode);
            count = (phase == 1) ? DEEP_ITEMS : $urandom_range(15, 50);
            for (int i = 0; i < count; i++) begin
                if (mode == TRAFFIC_SLOW_SINK && i == 5) hold_req = 1'b1;
                send_pixel(random_pixel());
                sent++;
            end
            wait_drained();
            phase++;
        end

        set_traffic(TRAFFIC_FREE);
        while (hold_req) @(negedge i_clk);
        wait_drained();
        repeat (60) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
